// ===== rtl/core/biquad_iir_filter_core_macros.svh =====
// Assertion macros for the biquad IIR filter core.
// Uses the including module's i_clk and i_rst_n; no other dependencies.
`ifndef BIQUAD_IIR_FILTER_CORE_MACROS_SVH
`define BIQUAD_IIR_FILTER_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle
`define BQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle
`define BQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/biquad_pkg.sv =====
// Shared constants and types for the biquad IIR filter core.
// No dependencies.
package biquad_pkg;

    // Field and datapath widths
    localparam int SECTION_ORDER  = 2;
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int CFG_BITS       = 20;
    localparam int CFG_COUNT      = 6;
    localparam int CFG_IDX_BITS   = $clog2(CFG_COUNT);
    localparam int STATE_BITS     = 32;
    localparam int PROD_BITS      = CFG_BITS + STATE_BITS;
    // Three products summed, plus rounding headroom
    localparam int ACC_BITS       = PROD_BITS + 2;
    localparam int QUOT_BITS      = ACC_BITS - COEF_FRAC_BITS;

    // Register reset values
    localparam logic signed [CFG_BITS-1:0] CFG_ONE  = CFG_BITS'(1) << COEF_FRAC_BITS;
    localparam logic signed [CFG_BITS-1:0] CFG_ZERO = '0;

    // Saturation limits
    localparam logic signed [STATE_BITS-1:0]  STATE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [STATE_BITS-1:0]  STATE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Round half up constant
    localparam logic signed [ACC_BITS-1:0] RND_HALF = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GAIN = 3'd0,
        CFG_A1   = 3'd1,
        CFG_A2   = 3'd2,
        CFG_B0   = 3'd3,
        CFG_B1   = 3'd4,
        CFG_B2   = 3'd5
    } t_cfg_idx;

endpackage

// ===== rtl/core/biquad_iir_filter_core.sv =====
// Biquad IIR filter core: direct form II second-order section on one shared MAC.
// Depends on biquad_pkg and biquad_iir_filter_core_macros.svh.
//
// A sample is handled in order by the idle state that accepts it, six passes
// through the single 20x32 multiplier with its registered product, an
// accumulate step for each sum that adds its last product, and one
// round-and-clamp step each for the internal value and the output. The core
// takes no new sample before it is through with the last. The input stall
// stays high while the sequencer is busy; a finished result waits in the
// output register and a new sample is accepted meanwhile. The result is only
// held back in its last step if the previous result has not yet been taken.
// Coefficient writes take effect at the next clock edge and must happen while
// the filter is idle.
`include "biquad_iir_filter_core_macros.svh"

module biquad_iir_filter_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [biquad_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [biquad_pkg::CFG_BITS-1:0]        i_cfg_data,
    // sample request in
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [biquad_pkg::SAMPLE_BITS-1:0] i_sample_in,
    // sample request out
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [biquad_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic                                   o_clipped
);
    import biquad_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_G,
        S_A1,
        S_A2,
        S_ACC1,
        S_W,
        S_B0,
        S_B1,
        S_B2,
        S_ACC2,
        S_Y
    } t_state;

    // Coefficient registers
    logic signed [CFG_BITS-1:0] r_gain, r_a1, r_a2, r_b0, r_b1, r_b2;

    // Sequencer, datapath and output registers
    t_state                        r_state, n_state;
    logic signed [SAMPLE_BITS-1:0] r_x, n_x;
    logic signed [PROD_BITS-1:0]   r_prod, n_prod;
    logic signed [ACC_BITS-1:0]    r_acc, n_acc;
    logic signed [STATE_BITS-1:0]  r_w, n_w;
    logic signed [STATE_BITS-1:0]  r_w1, n_w1;
    logic signed [STATE_BITS-1:0]  r_w2, n_w2;
    logic                          r_clip, n_clip;
    logic                          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample_out, n_sample_out;
    logic                          r_out_clip, n_out_clip;

    // Shared multiplier operands and result
    logic signed [CFG_BITS-1:0]    mul_a;
    logic signed [STATE_BITS-1:0]  mul_b;
    logic signed [PROD_BITS-1:0]   mul_p;
    logic signed [ACC_BITS-1:0]    prod_ext;

    // Shared rounder and clamps
    logic signed [ACC_BITS-1:0]    rnd;
    logic        [QUOT_BITS-1:0]   quot;
    logic                          w_hit, y_hit;
    logic signed [STATE_BITS-1:0]  w_sat;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic                          out_free;

    // Write coefficient registers; ignore indexes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= CFG_ONE;
            r_a1   <= CFG_ZERO;
            r_a2   <= CFG_ZERO;
            r_b0   <= CFG_ONE;
            r_b1   <= CFG_ZERO;
            r_b2   <= CFG_ZERO;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN: r_gain <= i_cfg_data;
                CFG_A1:   r_a1   <= i_cfg_data;
                CFG_A2:   r_a2   <= i_cfg_data;
                CFG_B0:   r_b0   <= i_cfg_data;
                CFG_B1:   r_b1   <= i_cfg_data;
                CFG_B2:   r_b2   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Select multiplier operands for the current step
    always_comb begin
        unique case (r_state)
            S_A1: begin
                mul_a = r_a1;
                mul_b = r_w1;
            end
            S_A2: begin
                mul_a = r_a2;
                mul_b = r_w2;
            end
            S_B0: begin
                mul_a = r_b0;
                mul_b = r_w;
            end
            S_B1: begin
                mul_a = r_b1;
                mul_b = r_w1;
            end
            S_B2: begin
                mul_a = r_b2;
                mul_b = r_w2;
            end
            default: begin
                mul_a = r_gain;
                mul_b = STATE_BITS'(r_x);
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_ext = ACC_BITS'(r_prod);

    // Round half up, then clamp to the state and sample ranges
    assign rnd   = r_acc + RND_HALF;
    assign quot  = rnd[ACC_BITS-1:COEF_FRAC_BITS];
    assign w_hit = !((&quot[QUOT_BITS-1:STATE_BITS-1]) || !(|quot[QUOT_BITS-1:STATE_BITS-1]));
    assign y_hit = !((&quot[QUOT_BITS-1:SAMPLE_BITS-1]) || !(|quot[QUOT_BITS-1:SAMPLE_BITS-1]));
    assign w_sat = w_hit ? (quot[QUOT_BITS-1] ? STATE_MIN : STATE_MAX)
                         : signed'(quot[STATE_BITS-1:0]);
    assign y_sat = y_hit ? (quot[QUOT_BITS-1] ? SMP_MIN : SMP_MAX)
                         : signed'(quot[SAMPLE_BITS-1:0]);

    // Output register can take a new result
    assign out_free = !r_out_valid || !i_out_stall;

    // Sequence the six products and two round steps
    always_comb begin
        n_state      = r_state;
        n_x          = r_x;
        n_prod       = r_prod;
        n_acc        = r_acc;
        n_w          = r_w;
        n_w1         = r_w1;
        n_w2         = r_w2;
        n_clip       = r_clip;
        n_sample_out = r_sample_out;
        n_out_clip   = r_out_clip;
        // drop the result once it is taken
        n_out_valid  = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_x     = i_sample_in;
                    n_clip  = 1'b0;
                    n_state = S_G;
                end
            end
            S_G: begin
                n_prod  = mul_p;
                n_state = S_A1;
            end
            S_A1: begin
                n_acc   = prod_ext;
                n_prod  = mul_p;
                n_state = S_A2;
            end
            S_A2: begin
                n_acc   = r_acc - prod_ext;
                n_prod  = mul_p;
                n_state = S_ACC1;
            end
            S_ACC1: begin
                n_acc   = r_acc - prod_ext;
                n_state = S_W;
            end
            S_W: begin
                n_w     = w_sat;
                n_clip  = w_hit;
                n_state = S_B0;
            end
            S_B0: begin
                n_prod  = mul_p;
                n_state = S_B1;
            end
            S_B1: begin
                n_acc   = prod_ext;
                n_prod  = mul_p;
                n_state = S_B2;
            end
            S_B2: begin
                n_acc   = r_acc + prod_ext;
                n_prod  = mul_p;
                n_state = S_ACC2;
            end
            S_ACC2: begin
                n_acc   = r_acc + prod_ext;
                n_state = S_Y;
            end
            S_Y: begin
                // hold until the output register is free, then advance the delay line
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_sample_out = y_sat;
                    n_out_clip   = r_clip || y_hit;
                    n_w1         = r_w;
                    n_w2         = r_w1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, delay line and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_w1        <= '0;
            r_w2        <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_w1         <= n_w1;
            r_w2         <= n_w2;
            r_x          <= n_x;
            r_prod       <= n_prod;
            r_acc        <= n_acc;
            r_w          <= n_w;
            r_clip       <= n_clip;
            r_sample_out <= n_sample_out;
            r_out_clip   <= n_out_clip;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_clipped    = r_out_clip;

    // A new sample always starts the gain product
    `BQ_ASSERT_NEXT(a_start_seq, i_in_valid && !o_in_stall, r_state == S_G, "sample not started")
    // A waiting result is never overwritten
    `BQ_ASSERT_NEXT(a_no_overwrite, r_state == S_Y && !out_free,
                    r_state == S_Y && $stable(r_sample_out), "result overwritten")
    // A result only appears out of the final step
    `BQ_ASSERT_SAME(a_out_from_y, $rose(o_out_valid), $past(r_state == S_Y),
                    "result without final step")
    // The delay line moves only when a result enters the output register
    `BQ_ASSERT_NEXT(a_delay_hold, r_state != S_Y, $stable(r_w1) && $stable(r_w2),
                    "delay line moved early")

endmodule

// ===== dv/biquad_response_checker.sv =====
// Response checker for the biquad IIR filter core: predicts each filtered sample
// and compares it with what leaves the output channel. Depends on biquad_pkg.
module biquad_response_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [biquad_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [biquad_pkg::CFG_BITS-1:0]        i_cfg_data,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_stall,
    input  logic [biquad_pkg::SAMPLE_BITS-1:0]     i_sample_in,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_stall,
    input  logic [biquad_pkg::SAMPLE_BITS-1:0]     i_sample_out,
    input  logic                                   i_clipped,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    import biquad_pkg::*;

    localparam int REPORT_MAX = 10;

    typedef struct {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   clipped;
        int                     seq;
    } t_filtered_sample;

    t_filtered_sample filtered_q[$];

    // Coefficients and delay line, all sign-extended to 64 bits
    longint gain, fb1, fb2, ff0, ff1, ff2;
    longint w1, w2;
    int     fail_cnt = 0;
    int     in_seq   = 0;

    // Round half up, then drop the fraction bits
    function automatic longint round_frac(input longint acc);
        return (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    endfunction

    function automatic longint saturate(input longint v, input longint lo, input longint hi,
                                        inout logic hit);
        if (v > hi) begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo) begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Run one sample through the section and advance the delay line
    function automatic t_filtered_sample filter_step(input logic [SAMPLE_BITS-1:0] x_raw);
        longint           x, acc, w, y;
        logic             hit;
        t_filtered_sample res;
        x   = longint'($signed(x_raw));
        hit = 1'b0;
        acc = gain * x - fb1 * w1 - fb2 * w2;
        w   = saturate(round_frac(acc), longint'(STATE_MIN), longint'(STATE_MAX), hit);
        acc = ff0 * w + ff1 * w1 + ff2 * w2;
        y   = saturate(round_frac(acc), longint'(SMP_MIN), longint'(SMP_MAX), hit);
        w2  = w1;
        w1  = w;
        res.sample  = y[SAMPLE_BITS-1:0];
        res.clipped = hit;
        res.seq     = in_seq;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_filtered_sample want;
        if (!i_rst_n) begin
            gain = longint'(CFG_ONE);
            fb1  = longint'(CFG_ZERO);
            fb2  = longint'(CFG_ZERO);
            ff0  = longint'(CFG_ONE);
            ff1  = longint'(CFG_ZERO);
            ff2  = longint'(CFG_ZERO);
            w1   = 0;
            w2   = 0;
            filtered_q.delete();
        end else begin
            // Track register writes; unused indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GAIN: gain = longint'($signed(i_cfg_data));
                    CFG_A1:   fb1  = longint'($signed(i_cfg_data));
                    CFG_A2:   fb2  = longint'($signed(i_cfg_data));
                    CFG_B0:   ff0  = longint'($signed(i_cfg_data));
                    CFG_B1:   ff1  = longint'($signed(i_cfg_data));
                    CFG_B2:   ff2  = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            // Compare each result request with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (filtered_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX)
                        $display("unexpected result: sample %0d clipped %0b",
                                 $signed(i_sample_out), i_clipped);
                end else begin
                    want = filtered_q.pop_front();
                    if (i_sample_out !== want.sample || i_clipped !== want.clipped) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_MAX)
                            $display("sample %0d: expected %0d clipped %0b, got %0d clipped %0b",
                                     want.seq, $signed(want.sample), want.clipped,
                                     $signed(i_sample_out), i_clipped);
                    end
                end
            end
            // Predict the result of each accepted request
            if (i_in_valid && !i_in_stall) begin
                filtered_q.push_back(filter_step(i_sample_in));
                in_seq++;
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= filtered_q.size();
    end

endmodule

// ===== dv/tb.sv =====
// Top of the biquad IIR filter core testbench: clock, reset, register setup and
// sample stimulus. Depends on biquad_pkg, biquad_iir_filter_core and the checker.
module tb;
    import biquad_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_ITEMS  = 112;
    localparam int RAND_PHASES  = 8;
    // Indexes past the last register, which the core must ignore
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_B = 3'd7;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]     cfg_data  = '0;
    logic                    in_valid  = 1'b0;
    logic [SAMPLE_BITS-1:0]  sample_in = '0;
    logic                    out_stall = 1'b0;
    logic                    in_stall;
    logic                    out_valid;
    logic [SAMPLE_BITS-1:0]  sample_out;
    logic                    clipped;

    int                      fail_count;
    int                      pending;
    int                      idle_pct    = 0;
    int                      stall_pct   = 0;
    int                      cycle_cnt   = 0;
    logic [SAMPLE_BITS-1:0]  last_sample = '0;

    biquad_iir_filter_core u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_sample_in  (sample_in),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_sample_out (sample_out),
        .o_clipped    (clipped)
    );

    biquad_response_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_sample_in  (sample_in),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_sample_out (sample_out),
        .i_clipped    (clipped),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #2 clk = ~clk;

    // Stall the output at random and stop a hung run
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        out_stall <= ($urandom_range(99) < stall_pct);
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Load all six registers, then drop the write enable
    task automatic load_coefs(input logic [CFG_BITS-1:0] g, input logic [CFG_BITS-1:0] a1,
                              input logic [CFG_BITS-1:0] a2, input logic [CFG_BITS-1:0] b0,
                              input logic [CFG_BITS-1:0] b1, input logic [CFG_BITS-1:0] b2);
        cfg_write(CFG_GAIN, g);
        cfg_write(CFG_A1, a1);
        cfg_write(CFG_A2, a2);
        cfg_write(CFG_B0, b0);
        cfg_write(CFG_B1, b1);
        cfg_write(CFG_B2, b2);
        cfg_we <= 1'b0;
    endtask

    // Offer one sample request, with an optional idle gap first
    task automatic push_sample(input logic [SAMPLE_BITS-1:0] x);
        if ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        in_valid  <= 1'b1;
        sample_in <= x;
        do @(posedge clk); while (in_stall);
        last_sample = x;
    endtask

    // Hold off until every predicted result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        cfg_we   <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [CFG_BITS-1:0] rand_coef();
        return CFG_BITS'($urandom);
    endfunction

    // Coefficient within +/-0.5, keeps the feedback mostly stable
    function automatic logic [CFG_BITS-1:0] mild_coef();
        return CFG_BITS'(int'($urandom_range(0, 65535)) - 32768);
    endfunction

    // Mix full-range noise, small signals, rails, steps and slow ramps
    function automatic logic [SAMPLE_BITS-1:0] next_sample(input logic [SAMPLE_BITS-1:0] prev);
        case ($urandom_range(9))
            0, 1, 2, 3: return SAMPLE_BITS'($urandom);
            4, 5:       return SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
            6:          return $urandom_range(1) ? SMP_MAX : SMP_MIN;
            7:          return prev;
            default:    return prev + SAMPLE_BITS'(int'($urandom_range(0, 2047)) - 1024);
        endcase
    endfunction

    task automatic load_phase_coefs(input int phase);
        case (phase)
            0: load_coefs(CFG_ONE, -20'sd74907, 20'sd27054, 20'sd4425, 20'sd8850, 20'sd4425);
            1: load_coefs(rand_coef(), rand_coef(), rand_coef(),
                          rand_coef(), rand_coef(), rand_coef());
            2: load_coefs(CFG_ONE, -20'sd74907, 20'sd27054, 20'sd41871, -20'sd83742, 20'sd41871);
            3: load_coefs(mild_coef(), -20'sd124518, 20'sd64880, CFG_ONE, CFG_ZERO, -20'sd65536);
            4: load_coefs(rand_coef(), mild_coef(), mild_coef(),
                          rand_coef(), rand_coef(), rand_coef());
            5: load_coefs(20'h80000, 20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h80000, 20'h7FFFF);
            6: load_coefs(rand_coef(), rand_coef(), rand_coef(),
                          rand_coef(), rand_coef(), rand_coef());
            default: load_coefs(rand_coef(), CFG_ZERO, CFG_ZERO, CFG_ONE, CFG_ZERO, CFG_ZERO);
        endcase
    endtask

    initial begin
        int phase;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset coefficients: straight pass-through of rails and bit patterns
        push_sample(SMP_MAX);
        push_sample(SMP_MIN);
        push_sample('0);
        push_sample(16'h0001);
        push_sample(16'hFFFF);
        push_sample(16'h5555);
        push_sample(16'hAAAA);
        drain_results();

        // Every register at its top: drive state and output into saturation
        load_coefs(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
        repeat (4) push_sample(SMP_MAX);
        repeat (2) push_sample(SMP_MIN);
        drain_results();

        // Every register at its bottom
        load_coefs(20'h80000, 20'h80000, 20'h80000, 20'h80000, 20'h80000, 20'h80000);
        repeat (3) push_sample(SMP_MIN);
        repeat (3) push_sample(SMP_MAX);
        drain_results();

        // Writes past the last register must leave unity pass-through intact
        load_coefs(CFG_ONE, CFG_ZERO, CFG_ZERO, CFG_ONE, CFG_ZERO, CFG_ZERO);
        cfg_write(CFG_IDX_SPARE_A, 20'h7FFFF);
        cfg_write(CFG_IDX_SPARE_B, 20'h80000);
        cfg_we <= 1'b0;
        push_sample(16'h1234);
        push_sample(16'hEDCB);
        push_sample(SMP_MAX);
        drain_results();

        // Random samples over several filter settings and handshake pressures
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 82; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            load_phase_coefs(phase);
            cfg_we <= 1'b0;
            repeat (PHASE_ITEMS) push_sample(next_sample(last_sample));
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
